FILE: rtl/cbfp_pkg.sv
package cbfp_pkg;

  // Register file limit, in 16-byte registers
  localparam int MAX_REGISTERS = 4096;
  localparam int REG_BYTES     = 16;
  localparam int LIMIT_BYTES   = MAX_REGISTERS * REG_BYTES;

  // Field widths fixed by the interface
  localparam int SIZE_W   = 11;
  localparam int COUNT_W  = 13;
  localparam int OFFS_W   = 16;
  localparam int TOTAL_W  = 17;
  localparam int IDX_W    = 13;
  localparam int FILL_W   = 4;
  localparam int POS_W    = IDX_W + FILL_W;
  // Worst-case unsaturated end: limit + 2048 * 8190 + 2047
  localparam int END_W    = 26;

  typedef struct packed {
    logic [SIZE_W-1:0]  element_bytes;
    logic [COUNT_W-1:0] array_count;
    logic               last_field;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [FILL_W-1:0] fill;
    logic              overflow;
  } pos_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  byte_offset;
    logic [SIZE_W-1:0]  element_stride;
    logic [TOTAL_W-1:0] total_bytes;
    logic               is_last;
    logic               overflow;
  } result_t;

endpackage

FILE: rtl/cbfp_layout.sv
module cbfp_layout (
  input  cbfp_pkg::item_t   item,
  input  cbfp_pkg::pos_t    pos,
  output cbfp_pkg::result_t res,
  output cbfp_pkg::pos_t    pos_next
);

  logic                        is_array;
  logic                        fits;
  logic [cbfp_pkg::IDX_W:0]    idx_up;
  logic [cbfp_pkg::POS_W:0]    start;
  logic [11:0]                 stride_full;
  logic [cbfp_pkg::COUNT_W-1:0] count_m1;
  logic [24:0]                 span;
  logic [cbfp_pkg::END_W-1:0]  end_raw;
  logic                        over;
  logic [cbfp_pkg::POS_W-1:0]  end_sat;
  logic [cbfp_pkg::POS_W:0]    total_up;

  always_comb begin
    is_array    = item.array_count > cbfp_pkg::COUNT_W'(1);
    idx_up      = {1'b0, pos.index} + (cbfp_pkg::IDX_W + 1)'(pos.fill != '0);
    fits        = (pos.fill != '0) &&
                  (({1'b0, item.element_bytes} + 12'(pos.fill)) <= 12'd16);
    if (!is_array && fits) begin
      start = {1'b0, pos.index, pos.fill};
    end else begin
      start = {idx_up, 4'b0000};
    end
    stride_full = ({1'b0, item.element_bytes} + 12'd15) & 12'hFF0;
    count_m1    = item.array_count - cbfp_pkg::COUNT_W'(1);
    span        = is_array ? (25'(stride_full) * 25'(count_m1)) : 25'd0;
    end_raw     = cbfp_pkg::END_W'(start) + cbfp_pkg::END_W'(span) +
                  cbfp_pkg::END_W'(item.element_bytes);
    over        = end_raw > cbfp_pkg::END_W'(cbfp_pkg::LIMIT_BYTES);
    end_sat     = over ? cbfp_pkg::POS_W'(cbfp_pkg::LIMIT_BYTES)
                       : end_raw[cbfp_pkg::POS_W-1:0];

    pos_next.index    = end_sat[cbfp_pkg::POS_W-1:cbfp_pkg::FILL_W];
    pos_next.fill     = end_sat[cbfp_pkg::FILL_W-1:0];
    pos_next.overflow = pos.overflow | over;

    total_up = {1'b0, end_sat} + (cbfp_pkg::POS_W + 1)'(15);

    res.byte_offset = (start[cbfp_pkg::POS_W:cbfp_pkg::OFFS_W] != '0) ?
                      '1 : start[cbfp_pkg::OFFS_W-1:0];
    if (is_array) begin
      res.element_stride = stride_full[11] ? '1 : stride_full[10:0];
    end else begin
      res.element_stride = item.element_bytes;
    end
    res.total_bytes = item.last_field ?
                      {total_up[cbfp_pkg::TOTAL_W-1:4], 4'b0000} : '0;
    res.is_last     = item.last_field;
    res.overflow    = pos_next.overflow;
  end

endmodule

FILE: rtl/cbfp_state.sv
module cbfp_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           close,
  input  cbfp_pkg::pos_t pos_next,
  output cbfp_pkg::pos_t pos
);

  always_ff @(posedge clk) begin
    if (rst || (advance && close)) begin
      pos <= '0;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

endmodule

FILE: rtl/constant_buffer_field_packer_top.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+------------------------------------------
// item     | item_valid / item_stall    | element_bytes, array_count, last_field
// result   | result_valid / result_stall| byte_offset, element_stride, total_bytes,
//          |                            | is_last, overflow
//
// One word in and one word out per cycle while result_stall is low; a word passes
// through the input register and then the result register, around the single layout pass.
// The running position (register index, fill, overflow) updates as a word moves
// into the result register, so the next word sees it with no bubble.
// Reset (rst, synchronous) empties both registers and clears the position.
// A stalled result holds its register; the input register still takes one word.
module constant_buffer_field_packer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [cbfp_pkg::SIZE_W-1:0]    element_bytes,
  input  logic [cbfp_pkg::COUNT_W-1:0]   array_count,
  input  logic                           last_field,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [cbfp_pkg::OFFS_W-1:0]    byte_offset,
  output logic [cbfp_pkg::SIZE_W-1:0]    element_stride,
  output logic [cbfp_pkg::TOTAL_W-1:0]   total_bytes,
  output logic                           is_last,
  output logic                           overflow
);

  cbfp_pkg::item_t   item;
  logic              item_full;
  logic              advance;
  cbfp_pkg::pos_t    pos;
  cbfp_pkg::pos_t    pos_next;
  cbfp_pkg::result_t res;
  cbfp_pkg::result_t result;

  // Advance the held word whenever the result register is free or being drained
  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item.element_bytes <= element_bytes;
      item.array_count   <= array_count;
      item.last_field    <= last_field;
    end
  end

  // Layout pass: place the field against the running position
  cbfp_layout u_layout (
    .item     (item),
    .pos      (pos),
    .res      (res),
    .pos_next (pos_next)
  );

  // Running position; drop back to zero after the closing field
  cbfp_state u_state (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .close    (item.last_field),
    .pos_next (pos_next),
    .pos      (pos)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  assign byte_offset    = result.byte_offset;
  assign element_stride = result.element_stride;
  assign total_bytes    = result.total_bytes;
  assign is_last        = result.is_last;
  assign overflow       = result.overflow;

endmodule

FILE: rtl/cbfp_checker.sv
module cbfp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [cbfp_pkg::OFFS_W-1:0]  byte_offset,
  input logic [cbfp_pkg::TOTAL_W-1:0] total_bytes,
  input logic                         is_last
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Total is only reported on the closing word
  a_total_only_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_last) |-> (total_bytes == '0))
    else $error("total on a non-closing word");

  // Buffer size is a whole number of registers
  a_total_aligned: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (total_bytes[3:0] == 4'd0))
    else $error("total not 16-byte aligned");

  // A stalled word stays valid and keeps its byte offset
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(byte_offset)))
    else $error("stalled result changed");

endmodule

bind constant_buffer_field_packer_top cbfp_checker u_cbfp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .byte_offset  (byte_offset),
  .total_bytes  (total_bytes),
  .is_last      (is_last)
);
